FILE: hdl/frame_deframer_xor_fcs_unit_assert.svh
// assertion macros for the deframer
`ifndef FRAME_DEFRAMER_XOR_FCS_UNIT_ASSERT_SVH
`define FRAME_DEFRAMER_XOR_FCS_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define FDX_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// next-cycle implication, disabled in reset
`define FDX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

FILE: hdl/fdxfcs_pkg.sv
package fdxfcs_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CmdW   = 4;
  localparam int unsigned LenW   = 6;
  localparam int unsigned KindW  = 2;
  localparam int unsigned TdataW = 48;
  localparam int unsigned FieldW = ByteW + LenW + CmdW + LenW + ByteW + ByteW + 1;

  typedef enum logic [1:0] {
    PH_HDR0 = 2'd0,
    PH_HDR1 = 2'd1,
    PH_BODY = 2'd2,
    PH_SKIP = 2'd3
  } phase_t;

  typedef enum logic [KindW-1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_SHORT = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [ByteW-1:0]  data_byte;
    logic [LenW-1:0]   data_index;
    logic [CmdW-1:0]   command;
    logic [LenW-1:0]   length;
    logic [ByteW-1:0]  received_fcs;
    logic [ByteW-1:0]  computed_fcs;
    logic              fcs_ok;
  } result_t;

endpackage

FILE: hdl/fdxfcs_parser.sv
module fdxfcs_parser
  import fdxfcs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [ByteW-1:0] rx_byte,
  input  logic             buffer_end,
  output logic             res_valid,
  output result_t          res
);

  phase_t           phase, phase_next;
  logic [CmdW-1:0]  held_command, held_command_next;
  logic [LenW-1:0]  held_length, held_length_next;
  logic [LenW-1:0]  payload_count, payload_count_next;
  logic [ByteW-1:0] fcs_acc, fcs_acc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HDR0;
      held_command  <= '0;
      held_length   <= '0;
      payload_count <= '0;
      fcs_acc       <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      held_command  <= held_command_next;
      held_length   <= held_length_next;
      payload_count <= payload_count_next;
      fcs_acc       <= fcs_acc_next;
    end
  end

  always_comb begin
    phase_next         = phase;
    held_command_next  = held_command;
    held_length_next   = held_length;
    payload_count_next = payload_count;
    fcs_acc_next       = fcs_acc;
    res_valid          = 1'b0;
    res                = '0;
    unique case (phase)
      PH_HDR0: begin
        held_command_next  = rx_byte[ByteW-1 -: CmdW];
        held_length_next   = '0;
        payload_count_next = '0;
        fcs_acc_next       = {rx_byte[ByteW-1 -: CmdW], {(ByteW-CmdW){1'b0}}};
        if (buffer_end) begin
          phase_next = PH_HDR0;
          res_valid  = 1'b1;
          res.kind   = KIND_SHORT;
        end else begin
          phase_next = PH_HDR1;
        end
      end
      PH_HDR1: begin
        held_length_next   = rx_byte[LenW-1:0];
        payload_count_next = '0;
        fcs_acc_next       = fcs_acc ^ {{(ByteW-LenW){1'b0}}, rx_byte[LenW-1:0]};
        if (buffer_end) begin
          phase_next = PH_HDR0;
          res_valid  = 1'b1;
          res.kind   = KIND_SHORT;
        end else begin
          phase_next = PH_BODY;
        end
      end
      PH_BODY: begin
        res_valid = 1'b1;
        if (payload_count < held_length) begin
          if (buffer_end) begin
            phase_next = PH_HDR0;
            res.kind   = KIND_SHORT;
          end else begin
            res.kind           = KIND_DATA;
            res.data_byte      = rx_byte;
            res.data_index     = payload_count;
            fcs_acc_next       = fcs_acc ^ rx_byte;
            payload_count_next = payload_count + LenW'(1);
          end
        end else begin
          res.kind         = KIND_DONE;
          res.received_fcs = rx_byte;
          res.computed_fcs = fcs_acc;
          res.fcs_ok       = (rx_byte == fcs_acc);
          phase_next       = buffer_end ? PH_HDR0 : PH_SKIP;
        end
      end
      PH_SKIP: begin
        if (buffer_end) phase_next = PH_HDR0;
      end
      default: phase_next = PH_HDR0;
    endcase
    // header fields as they stand after this byte
    res.command = held_command_next;
    res.length  = held_length_next;
  end

endmodule

FILE: hdl/frame_deframer_xor_fcs_unit.sv
// Length-prefixed frame deframer with an XOR frame check. Received buffer bytes come in
// one per s_ transfer, s_tlast on the buffer's last byte. Byte 0 holds the command in its
// high nibble, byte 1 the payload length in its low six bits, then the payload and one FCS
// byte. Each payload byte gives a data result with its index; the FCS byte gives a frame
// result with the received and computed FCS and a match flag; a buffer that ends before
// the FCS byte gives a short-frame result, and bytes after the FCS are dropped. Each byte
// passes through the header and payload state registers into a single result
// register, so a byte can be taken every cycle while m_tready is high; input stalls
// only while that result register is full and not being taken.
`include "frame_deframer_xor_fcs_unit_assert.svh"

module frame_deframer_xor_fcs_unit
  import fdxfcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [ByteW-1:0]  s_tdata,   // rx_byte
  input  logic              s_tlast,   // buffer_end
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [TdataW-1:0] m_tdata,   // data_byte, data_index, command, length,
                                       // received_fcs, computed_fcs, fcs_ok, zero fill
  output logic [KindW-1:0]  m_tuser    // kind
);

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_reg;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  fdxfcs_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .rx_byte    (s_tdata),
    .buffer_end (s_tlast),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= accept && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res_valid) out_reg <= res;
  end

  assign m_tuser = out_reg.kind;
  assign m_tdata = {{(TdataW-FieldW){1'b0}}, out_reg.fcs_ok, out_reg.computed_fcs,
                    out_reg.received_fcs, out_reg.length, out_reg.command,
                    out_reg.data_index, out_reg.data_byte};

  `FDX_ASSERT_NOW(a_idle_ready, !m_tvalid, s_tready)
  `FDX_ASSERT_NOW(a_data_index, m_tvalid && m_tuser == KIND_DATA,
                  out_reg.data_index < out_reg.length)
  `FDX_ASSERT_NOW(a_fcs_flag, m_tvalid && m_tuser == KIND_DONE,
                  out_reg.fcs_ok == (out_reg.received_fcs == out_reg.computed_fcs))
  `FDX_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

FILE: test/fcs_frame_checker.sv
`timescale 1ns / 100ps

module fcs_frame_checker
  import fdxfcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [ByteW-1:0]  s_tdata,   // rx_byte
  input  logic              s_tlast,   // buffer_end
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [TdataW-1:0] m_tdata,   // data_byte, data_index, command, length,
                                       // received_fcs, computed_fcs, fcs_ok, zero fill
  input  logic [KindW-1:0]  m_tuser,   // kind
  output int                mismatches,
  output int                pending,
  output int                data_seen,
  output int                frames_seen,
  output int                shorts_seen,
  output int                bad_fcs_seen
);

  phase_t           rx_phase;
  logic [CmdW-1:0]  rx_cmd;
  logic [LenW-1:0]  rx_len;
  logic [LenW-1:0]  rx_count;
  logic [ByteW-1:0] rx_acc;
  result_t          expected_results[$];
  result_t          got;
  result_t          want;

  task automatic report(input string what, input result_t g, input result_t w);
    if (mismatches < 30) begin
      $display("%0t: %s: got kind=%0d byte=%h idx=%0d cmd=%h len=%0d rfcs=%h cfcs=%h ok=%b",
               $time, what, g.kind, g.data_byte, g.data_index, g.command, g.length,
               g.received_fcs, g.computed_fcs, g.fcs_ok,
               " expected kind=%0d byte=%h idx=%0d cmd=%h len=%0d rfcs=%h cfcs=%h ok=%b",
               w.kind, w.data_byte, w.data_index, w.command, w.length,
               w.received_fcs, w.computed_fcs, w.fcs_ok);
    end
    mismatches = mismatches + 1;
  endtask

  // advance the deframer state by one buffer byte and queue any result it causes
  task automatic deframe_byte(input logic [ByteW-1:0] b, input logic eob);
    result_t r;
    logic    emit;
    r    = '0;
    emit = 1'b0;
    case (rx_phase)
      PH_HDR0: begin
        rx_cmd   = b[7:4];
        rx_len   = '0;
        rx_count = '0;
        rx_acc   = {b[7:4], 4'h0};
        if (eob) begin
          emit   = 1'b1;
          r.kind = KIND_SHORT;
        end else begin
          rx_phase = PH_HDR1;
        end
      end
      PH_HDR1: begin
        rx_len   = b[LenW-1:0];
        rx_count = '0;
        rx_acc   = rx_acc ^ {2'b00, b[LenW-1:0]};
        emit     = eob;
        r.kind   = KIND_SHORT;
        rx_phase = eob ? PH_HDR0 : PH_BODY;
      end
      PH_BODY: begin
        emit = 1'b1;
        if (rx_count < rx_len) begin
          if (eob) begin
            r.kind   = KIND_SHORT;
            rx_phase = PH_HDR0;
          end else begin
            r.kind       = KIND_DATA;
            r.data_byte  = b;
            r.data_index = rx_count;
            rx_acc       = rx_acc ^ b;
            rx_count     = rx_count + 1'b1;
          end
        end else begin
          r.kind         = KIND_DONE;
          r.received_fcs = b;
          r.computed_fcs = rx_acc;
          r.fcs_ok       = (b == rx_acc);
          rx_phase       = eob ? PH_HDR0 : PH_SKIP;
        end
      end
      default: begin
        if (eob) rx_phase = PH_HDR0;
      end
    endcase
    if (emit) begin
      r.command = rx_cmd;
      r.length  = rx_len;
      expected_results.insert(expected_results.size(), r);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rx_phase     = PH_HDR0;
      rx_cmd       = '0;
      rx_len       = '0;
      rx_count     = '0;
      rx_acc       = '0;
      expected_results.delete();
      mismatches   = 0;
      data_seen    = 0;
      frames_seen  = 0;
      shorts_seen  = 0;
      bad_fcs_seen = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got              = '0;
        got.kind         = kind_t'(m_tuser);
        got.data_byte    = m_tdata[7:0];
        got.data_index   = m_tdata[13:8];
        got.command      = m_tdata[17:14];
        got.length       = m_tdata[23:18];
        got.received_fcs = m_tdata[31:24];
        got.computed_fcs = m_tdata[39:32];
        got.fcs_ok       = m_tdata[40];
        if (expected_results.size() == 0) begin
          report("result with nothing expected", got, '0);
        end else begin
          want = expected_results.pop_front();
          if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
              got.data_index !== want.data_index || got.command !== want.command ||
              got.length !== want.length || got.received_fcs !== want.received_fcs ||
              got.computed_fcs !== want.computed_fcs || got.fcs_ok !== want.fcs_ok)
            report("result mismatch", got, want);
          case (want.kind)
            KIND_DATA: data_seen = data_seen + 1;
            KIND_DONE: begin
              frames_seen = frames_seen + 1;
              if (!want.fcs_ok) bad_fcs_seen = bad_fcs_seen + 1;
            end
            default: shorts_seen = shorts_seen + 1;
          endcase
        end
      end
      if (s_tvalid && s_tready) deframe_byte(s_tdata, s_tlast);
    end
    pending = expected_results.size();
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import fdxfcs_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int RandomItems = 1550;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic [ByteW-1:0]  s_tdata  = '0;
  logic              s_tlast  = 1'b0;
  logic              m_tready = 1'b0;
  logic              s_tready;
  logic              m_tvalid;
  logic [TdataW-1:0] m_tdata;
  logic [KindW-1:0]  m_tuser;

  int mismatches;
  int pending;
  int data_seen;
  int frames_seen;
  int shorts_seen;
  int bad_fcs_seen;
  int cycles        = 0;
  int rx_stall      = 0;
  int rx_next;
  int bytes_counted = 0;
  int buffers_sent  = 0;
  int random_items  = 0;
  bit paused        = 1'b0;

  logic [8:0] byte_q[$];  // {buffer end, byte}

  frame_deframer_xor_fcs_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  fcs_frame_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tlast      (s_tlast),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .mismatches   (mismatches),
    .pending      (pending),
    .data_seen    (data_seen),
    .frames_seen  (frames_seen),
    .shorts_seen  (shorts_seen),
    .bad_fcs_seen (bad_fcs_seen)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: stall a random number of cycles after each transfer
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_stall <= 0;
    end else begin
      if (m_tvalid && m_tready)
        rx_next = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      else
        rx_next = rx_stall;
      if (rx_next > 0) begin
        m_tready <= 1'b0;
        rx_stall <= rx_next - 1;
      end else begin
        m_tready <= 1'b1;
        rx_stall <= 0;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic eob);
    byte_q.insert(byte_q.size(), {eob, b});
  endtask

  task automatic send_buffer();
    logic [8:0] item;
    int         gap;
    bit         calm;
    calm = ($urandom_range(0, 3) == 0);
    while (byte_q.size() > 0) begin
      item = byte_q.pop_front();
      gap  = calm ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= item[7:0];
      s_tlast  <= item[8];
      do @(posedge clk); while (!s_tready);
    end
    buffers_sent++;
  endtask

  // style 0: well-formed frame, fcs sometimes bad, maybe trailing bytes, 1: buffer cut before the fcs, 2: random noise
  task automatic build_buffer(input int style, output int counted);
    logic [7:0] fb[0:65];
    logic [3:0] cmd;
    logic [5:0] flen;
    logic [7:0] acc;
    int         pick;
    int         total;
    int         trail;
    int         cut;
    pick = $urandom_range(0, 99);
    cmd  = 4'($urandom);
    flen = (pick < 3) ? 6'd63 :
           (pick < 12) ? 6'($urandom_range(9, 62)) : 6'($urandom_range(0, 8));
    acc  = {cmd, 4'h0} ^ {2'b00, flen};
    fb[0] = {cmd, 4'($urandom)};
    fb[1] = {2'($urandom), flen};
    for (int i = 0; i < flen; i++) begin
      fb[i + 2] = 8'($urandom);
      acc = acc ^ fb[i + 2];
    end
    fb[flen + 2] = ($urandom_range(0, 4) == 0) ? 8'($urandom) : acc;
    total = flen + 3;
    if (style == 0) begin
      trail = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
      for (int i = 0; i < total; i++) push_byte(fb[i], i == total - 1 && trail == 0);
      for (int i = 0; i < trail; i++) push_byte(8'($urandom), i == trail - 1);
      counted = total + trail;
    end else if (style == 1) begin
      cut = $urandom_range(0, flen + 1);
      for (int i = 0; i <= cut; i++) push_byte(fb[i], i == cut);
      counted = cut + 1;
    end else begin
      cut = $urandom_range(1, 6);
      for (int i = 0; i < cut; i++) push_byte(8'($urandom), i == cut - 1);
      counted = cut;
    end
  endtask

  initial begin
    int pick;
    int counted;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // buffer ends on header byte 0
    push_byte(8'hFF, 1'b1);
    send_buffer();
    // buffer ends on header byte 1
    push_byte(8'h00, 1'b0); push_byte(8'hFF, 1'b1);
    send_buffer();
    // zero length, good fcs, buffer ends at the fcs
    push_byte(8'hA5, 1'b0); push_byte(8'hC0, 1'b0); push_byte(8'hA0, 1'b1);
    send_buffer();
    // bad fcs followed by trailing bytes
    push_byte(8'h3C, 1'b0); push_byte(8'h02, 1'b0); push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0); push_byte(8'h32, 1'b0); push_byte(8'h55, 1'b0);
    push_byte(8'hAA, 1'b1);
    send_buffer();
    // buffer ends inside the payload
    push_byte(8'hF0, 1'b0); push_byte(8'h03, 1'b0); push_byte(8'h11, 1'b0);
    push_byte(8'h22, 1'b1);
    send_buffer();
    // one payload byte, good fcs, one trailing byte
    push_byte(8'h70, 1'b0); push_byte(8'h01, 1'b0); push_byte(8'h80, 1'b0);
    push_byte(8'hF1, 1'b0); push_byte(8'h00, 1'b1);
    send_buffer();
    bytes_counted = 22;

    while (random_items < RandomItems) begin
      pick = $urandom_range(0, 99);
      build_buffer((pick < 75) ? 0 : (pick < 90) ? 1 : 2, counted);
      send_buffer();
      random_items  += counted;
      bytes_counted += counted;
      if (!paused && random_items >= RandomItems / 2) begin
        paused = 1'b1;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
    end
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("sent %0d buffers (%0d bytes): %0d frames checked, %0d of them with a bad fcs",
             buffers_sent, bytes_counted, frames_seen, bad_fcs_seen);
    $display("%0d short buffers, %0d payload bytes, %0d mismatches",
             shorts_seen, data_seen, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: frame_deframer_xor_fcs_unit.f
+incdir+hdl
hdl/fdxfcs_pkg.sv
hdl/fdxfcs_parser.sv
hdl/frame_deframer_xor_fcs_unit.sv
test/fcs_frame_checker.sv
test/testbench.sv
